[rtl/conv3x3_box_filter_unit_assert.svh]
// Assertion macros, clocked on clk, off while arst_n is low
`ifndef CONV3X3_BOX_FILTER_UNIT_ASSERT_SVH
`define CONV3X3_BOX_FILTER_UNIT_ASSERT_SVH

// sig holds in the cycle after cond
`define CBF_ASSERT_HOLD(lbl, cond, sig, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
else $error(msg);

// expr holds whenever cond holds
`define CBF_ASSERT_NOW(lbl, cond, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
else $error(msg);

`endif

[rtl/cbf_pkg.sv]
package cbf_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int AW        = $clog2(MAX_WIDTH);
	localparam int CW        = 13;
	localparam int RW        = CW + 1;
	localparam int TW        = 12;
	localparam int PAW       = 4;

	localparam logic [CW-1:0] WIDTH_RST  = CW'(640);
	localparam logic [CW-1:0] HEIGHT_RST = CW'(480);

	// floor(x * RECIP9 / 2^16) == floor(x / 9) for x < 2^12
	localparam logic [12:0] RECIP9 = 13'd7282;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	typedef enum logic [1:0] {
		MODE_SMOOTH = 2'd0,
		MODE_SHARP  = 2'd1,
		MODE_BAND   = 2'd2
	} mode_t;

	typedef struct packed {
		logic          rd;
		logic [AW-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic          v;
		logic [AW-1:0] col;
		logic [7:0]    fresh;
		logic          primed;
		logic          col_lo;
		logic          col_hi;
		logic          row_lo;
		logic          row_hi;
		logic          last;
	} s1_t;

	typedef struct packed {
		logic          v;
		logic [TW-1:0] total;
		logic [7:0]    centre;
		logic          last;
	} s2_t;

endpackage

[rtl/cbf_pos_ctrl.sv]
module cbf_pos_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic               pipe_en,
	input  logic               accept,
	input  logic [7:0]         pixel_in,
	input  logic               flush,
	input  logic [12:0]        eff_w,
	input  logic [12:0]        eff_h,
	output cbf_pkg::mem_rd_t   rd,
	output cbf_pkg::s1_t       item_s1
);
	import cbf_pkg::*;

	logic [AW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [AW-1:0] in_col_d, out_col_d;
	logic [RW-1:0] in_row_d, out_row_d;
	logic [CW-1:0] col_nx, ocol_nx;
	logic          draining, live, primed, last;
	s1_t           s1_d;

	always_comb begin
		draining = in_row_q >= RW'(eff_h);
		live     = accept && (draining || !flush);
		primed   = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);

		s1_d.v      = live;
		s1_d.col    = (CW'(in_col_q) < eff_w) ? in_col_q : '0;
		s1_d.fresh  = draining ? 8'd0 : pixel_in;
		s1_d.primed = primed;
		s1_d.col_lo = out_col_q == '0;
		s1_d.col_hi = CW'(out_col_q) >= eff_w - CW'(1);
		s1_d.row_lo = out_row_q == '0;
		s1_d.row_hi = out_row_q >= RW'(eff_h) - RW'(1);
		last        = primed && s1_d.col_hi && s1_d.row_hi;
		s1_d.last   = last;

		rd.rd   = live;
		rd.addr = s1_d.col;

		col_nx = CW'(in_col_q) + CW'(1);
		if (col_nx >= eff_w) begin
			in_col_d = '0;
			in_row_d = in_row_q + RW'(1);
		end else begin
			in_col_d = col_nx[AW-1:0];
			in_row_d = in_row_q;
		end

		ocol_nx   = CW'(out_col_q) + CW'(1);
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (primed) begin
			if (ocol_nx >= eff_w) begin
				out_col_d = '0;
				out_row_d = out_row_q + RW'(1);
			end else begin
				out_col_d = ocol_nx[AW-1:0];
			end
		end

		if (last) begin
			in_col_d  = '0;
			in_row_d  = '0;
			out_col_d = '0;
			out_row_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (live) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (pipe_en) begin
			item_s1 <= s1_d;
		end
	end

endmodule

[rtl/cbf_window.sv]
module cbf_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic             pipe_en,
	input  cbf_pkg::mem_rd_t rd,
	input  cbf_pkg::s1_t     item_s1,
	output cbf_pkg::s2_t     item_s2
);
	import cbf_pkg::*;

	logic [7:0] mem_a [MAX_WIDTH];
	logic [7:0] mem_b [MAX_WIDTH];
	logic [7:0] rd_a_q, rd_b_q, byp_a_q, byp_b_q;
	logic       byp_q;
	logic       wr;
	logic [7:0] top, mid;
	logic [7:0] win_q [9];
	logic [7:0] win_d [9];
	logic [7:0] rsel [3][3];
	logic [7:0] px   [3][3];
	logic [9:0] rsum [3];
	logic [TW-1:0] total;

	assign wr  = pipe_en && item_s1.v;
	assign top = byp_q ? byp_a_q : rd_a_q;
	assign mid = byp_q ? byp_b_q : rd_b_q;

	// middle row moves up into store a, new pixel goes to store b
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_a[item_s1.col] <= mid;
			mem_b[item_s1.col] <= item_s1.fresh;
		end
		if (rd.rd) begin
			rd_a_q  <= mem_a[rd.addr];
			rd_b_q  <= mem_b[rd.addr];
			byp_a_q <= mid;
			byp_b_q <= item_s1.fresh;
		end
	end

	// same column written and read in one cycle (one-pixel rows)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd.rd) begin
			byp_q <= wr && (item_s1.col == rd.addr);
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r*3]     = win_q[r*3+1];
			win_d[r*3+1]   = win_q[r*3+2];
		end
		win_d[2] = top;
		win_d[5] = mid;
		win_d[8] = item_s1.fresh;

		// edge replication: outer rows/cols fall back to the middle one
		for (int k = 0; k < 3; k++) begin
			rsel[0][k] = item_s1.row_lo ? win_d[3+k] : win_d[k];
			rsel[1][k] = win_d[3+k];
			rsel[2][k] = item_s1.row_hi ? win_d[3+k] : win_d[6+k];
		end
		for (int r = 0; r < 3; r++) begin
			px[r][0] = item_s1.col_lo ? rsel[r][1] : rsel[r][0];
			px[r][1] = rsel[r][1];
			px[r][2] = item_s1.col_hi ? rsel[r][1] : rsel[r][2];
			rsum[r]  = 10'(px[r][0]) + 10'(px[r][1]) + 10'(px[r][2]);
		end
		total = TW'(rsum[0]) + TW'(rsum[1]) + TW'(rsum[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= 8'd0;
			end
		end else if (restart) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= 8'd0;
			end
		end else if (wr) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (pipe_en) begin
			item_s2.v      <= item_s1.v && item_s1.primed;
			item_s2.total  <= total;
			item_s2.centre <= win_d[4];
			item_s2.last   <= item_s1.last;
		end
	end

endmodule

[rtl/cbf_filter.sv]
module cbf_filter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pipe_en,
	input  cbf_pkg::mode_t mode,
	input  cbf_pkg::s2_t   item_s2,
	output logic           res_valid,
	output logic [7:0]     pixel_out,
	output logic           frame_end
);
	import cbf_pkg::*;

	logic signed [13:0] c10, c9, tot, sharp, band, val;
	logic [TW-1:0]      rnd;
	logic [24:0]        prod;
	logic [7:0]         clamped;
	logic               valid_q, last_q;
	logic [7:0]         pix_q;

	always_comb begin
		c10   = 14'(signed'({1'b0, item_s2.centre, 3'b000}))
		      + 14'(signed'({1'b0, item_s2.centre, 1'b0}));
		c9    = 14'(signed'({1'b0, item_s2.centre, 3'b000}))
		      + 14'(signed'({1'b0, item_s2.centre}));
		tot   = 14'(signed'({1'b0, item_s2.total}));
		sharp = c10 - tot;
		band  = tot - c9;
		rnd   = item_s2.total + TW'(4);
		prod  = 25'(rnd) * 25'(RECIP9);

		case (mode)
			MODE_SHARP: val = sharp;
			MODE_BAND:  val = band;
			default:    val = 14'(signed'({1'b0, prod[24:16]}));
		endcase

		if (val < 0) begin
			clamped = 8'd0;
		end else if (val > 14'sd255) begin
			clamped = 8'd255;
		end else begin
			clamped = val[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pipe_en) begin
			valid_q <= item_s2.v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pix_q  <= clamped;
			last_q <= item_s2.last;
		end
	end

	assign res_valid = valid_q;
	assign pixel_out = pix_q;
	assign frame_end = last_q;

endmodule

[rtl/conv3x3_box_filter_unit.sv]
// channel  | signals                          | request moves
// ---------+----------------------------------+--------------------------------
// s_       | tvalid tready tdata[7:0] tuser   | source pixel, tuser = flush
// m_       | tvalid tready tdata[7:0] tlast   | filtered pixel, tlast = frame end
// apb      | psel penable pwrite paddr pwdata | width 0x0, height 0x4, mode 0x8
//
// One request per clock unless the output stalls. A result passes the line
// store read, window sum and filter/output register after the request that
// completes its window. m_tready low while m_tvalid is high holds the whole
// pipeline and drops s_tready in the same cycle.
// Reset clears counters and window; line stores are not cleared, no init pass.
// A frame takes W+1 flush requests after the last pixel to drain.
module conv3x3_box_filter_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [cbf_pkg::PAW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,  // [7:0] pixel_in
	input  logic                    s_tuser,  // [0] flush
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,  // [7:0] pixel_out
	output logic                    m_tlast
);
	import cbf_pkg::*;

	logic [CW-1:0] width_q, height_q;
	logic [1:0]    mode_q;
	logic [CW-1:0] eff_w, eff_h;
	logic [1:0]    idx;
	logic          cfg_wr, restart, pipe_en, accept;
	mem_rd_t       rd;
	s1_t           item_s1;
	s2_t           item_s2;

	assign pready  = 1'b1;
	assign idx     = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign restart = cfg_wr && (idx inside {REG_WIDTH, REG_HEIGHT, REG_MODE});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q   <= MODE_SMOOTH;
		end else if (cfg_wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[CW-1:0];
				REG_HEIGHT: height_q <= pwdata[CW-1:0];
				REG_MODE:   mode_q   <= pwdata[1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_MODE:   prdata = 32'(mode_q);
			default:    prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = CW'(1);
		end else if (width_q > CW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q == '0) ? CW'(1) : height_q;
	end

	assign pipe_en  = !m_tvalid || m_tready;
	assign s_tready = pipe_en;
	assign accept   = s_tvalid && s_tready;

	cbf_pos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.pipe_en  (pipe_en),
		.accept   (accept),
		.pixel_in (s_tdata),
		.flush    (s_tuser),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.rd       (rd),
		.item_s1  (item_s1)
	);

	cbf_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.pipe_en (pipe_en),
		.rd      (rd),
		.item_s1 (item_s1),
		.item_s2 (item_s2)
	);

	cbf_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.pipe_en   (pipe_en),
		.mode      (mode_t'(mode_q)),
		.item_s2   (item_s2),
		.res_valid (m_tvalid),
		.pixel_out (m_tdata),
		.frame_end (m_tlast)
	);

`include "conv3x3_box_filter_unit_assert.svh"

	`CBF_ASSERT_HOLD(a_s1_hold, !pipe_en, item_s1, "stage 1 moved during stall")
	`CBF_ASSERT_HOLD(a_s2_hold, !pipe_en, item_s2, "stage 2 moved during stall")
	`CBF_ASSERT_NOW(a_sum_range, item_s2.v, item_s2.total <= TW'(2295), "window sum out of range")

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cbf_pkg::*;

	localparam real CLK_PERIOD   = 12.0;
	localparam int  RESET_CYCLES = 4;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  RANDOM_ITEMS = 1400;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  MAX_REPORTS  = 40;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] px;
		logic       last;
	} result_t;

	// typed expectation attached to a directed request
	typedef struct packed {
		logic    typed;
		result_t res;
	} tag_t;

	typedef struct packed {
		logic          is_cfg;
		logic [1:0]    reg_idx;
		logic [CW-1:0] value;
		logic [7:0]    pix;
		logic          flush;
		tag_t          tag;
	} stim_row_t;

	localparam tag_t NO_TAG = '0;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [PAW-1:0]    paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;  // [7:0] pixel_in
	logic              s_tuser  = 1'b0; // [0] flush
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;         // [7:0] pixel_out
	logic              m_tlast;         // [0] frame_end

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches    = 0;
	int          cycle_count   = 0;
	int          cur_w         = 640;
	int          cur_h         = 480;

	// filter model state
	logic [CW-1:0] fw_reg   = WIDTH_RST;
	logic [CW-1:0] fh_reg   = HEIGHT_RST;
	logic [1:0]    mode_reg = MODE_SMOOTH;
	bit [7:0]      store_above [MAX_WIDTH];
	bit [7:0]      store_prev [MAX_WIDTH];
	bit [7:0]      win [9];
	int unsigned   in_col, in_row, out_col, out_row;

	result_t   expected_pixels [$];
	tag_t      directed_tags [$];
	stim_row_t directed_rows [$];

	conv3x3_box_filter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL conv3x3_box_filter_unit");
			$finish;
		end
	end

	function automatic int eff_width(input logic [CW-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(v);
	endfunction

	function automatic int eff_height(input logic [CW-1:0] v);
		return (v == 0) ? 1 : int'(v);
	endfunction

	function automatic void restart_frame();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
		for (int i = 0; i < 9; i++)
			win[i] = 8'd0;
	endfunction

	function automatic void write_filter_reg(input logic [1:0] idx, input logic [31:0] data);
		if (idx == REG_WIDTH)
			fw_reg = data[CW-1:0];
		else if (idx == REG_HEIGHT)
			fh_reg = data[CW-1:0];
		else if (idx == REG_MODE)
			mode_reg = data[1:0];
		else
			return;
		restart_frame();
	endfunction

	function automatic bit box_filter_step(input logic [7:0] pix, input logic flush,
			output result_t res);
		int unsigned w, h, c, ox, oy;
		int unsigned rows [3];
		int unsigned cols [3];
		bit [7:0]    top, mid, fresh;
		int          total, ctr, v;
		bit          draining, primed;
		w = eff_width(fw_reg);
		h = eff_height(fh_reg);
		res = '0;
		draining = (in_row >= h);
		if (!draining && flush)
			return 1'b0;
		c = (in_col < w) ? in_col : 0;
		fresh = draining ? 8'd0 : pix;
		top = store_above[c];
		mid = store_prev[c];
		store_above[c] = mid;
		store_prev[c] = fresh;
		for (int r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = fresh;
		primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!primed)
			return 1'b0;
		ox = out_col;
		oy = out_row;
		// edges replicate the nearest pixel
		rows[0] = (oy == 0) ? 1 : 0;
		rows[1] = 1;
		rows[2] = (oy >= h - 1) ? 1 : 2;
		cols[0] = (ox == 0) ? 1 : 0;
		cols[1] = 1;
		cols[2] = (ox >= w - 1) ? 1 : 2;
		total = 0;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				total += int'(win[rows[r]*3 + cols[k]]);
		ctr = int'(win[4]);
		if (mode_reg == MODE_SHARP)
			v = 10 * ctr - total;
		else if (mode_reg == MODE_BAND)
			v = total - 9 * ctr;
		else
			v = (total + 4) / 9;
		if (v > 255)
			v = 255;
		if (v < 0)
			v = 0;
		res.px = v[7:0];
		res.last = (ox >= w - 1) && (oy >= h - 1);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		if (res.last) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("%0t ns mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : monitor
		tag_t    tag;
		result_t pred;
		result_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				write_filter_reg(paddr[3:2], pwdata);
			if (s_tvalid && s_tready) begin
				tag = directed_tags.pop_front();
				if (box_filter_step(s_tdata, s_tuser, pred))
					expected_pixels.push_back(tag.typed ? tag.res : pred);
			end
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel %02h last %b", m_tdata, m_tlast));
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want.px)
						report_mismatch($sformatf("pixel_out %02h, want %02h",
							m_tdata, want.px));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("frame_end %b, want %b",
							m_tlast, want.last));
				end
			end
		end
	end

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_item(input logic [7:0] pix, input logic flush, input tag_t tag);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			@(posedge clk);
		end
		directed_tags.push_back(tag);
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= flush;
		do @(posedge clk); while (!s_tready);
	endtask

	// waits for the block to go quiet, then drives an APB setup phase and an access phase
	task automatic apb_write(input logic [1:0] idx, input logic [CW-1:0] value);
		logic [31:0] data;
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		data = $urandom;
		if (idx == REG_MODE)
			data[1:0] = value[1:0];
		else
			data[CW-1:0] = value;
		if (idx == REG_WIDTH)
			cur_w = eff_width(value);
		if (idx == REG_HEIGHT)
			cur_h = eff_height(value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// n_items below W*H+W+1 leaves a partial frame
	task automatic run_frame(input int n_items, inout int sent);
		int npx;
		npx = cur_w * cur_h;
		for (int i = 0; i < n_items; i++) begin
			if (i < npx) begin
				if ($urandom_range(99) < 4)
					send_item(8'($urandom), 1'b1, NO_TAG);
				send_item(rand_pixel(), 1'b0, NO_TAG);
			end else begin
				send_item(rand_pixel(), $urandom_range(99) >= 20, NO_TAG);
			end
			sent++;
		end
	endtask

	function automatic void row_cfg(input logic [1:0] idx, input logic [CW-1:0] value);
		directed_rows.push_back({1'b1, idx, value, 8'h00, 1'b0, NO_TAG});
	endfunction

	function automatic void row_px(input logic [7:0] pix, input logic flush);
		directed_rows.push_back({1'b0, 2'b00, {CW{1'b0}}, pix, flush, NO_TAG});
	endfunction

	function automatic void row_chk(input logic [7:0] pix, input logic flush,
			input logic [7:0] px, input logic last);
		directed_rows.push_back({1'b0, 2'b00, {CW{1'b0}}, pix, flush, 1'b1, px, last});
	endfunction

	function automatic logic [CW-1:0] rand_width();
		case ($urandom_range(9))
			0: return '0;
			1: return CW'($urandom_range(9, 24));
			default: return CW'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [CW-1:0] rand_height();
		case ($urandom_range(9))
			0: return '0;
			1: return CW'($urandom_range(6, 12));
			default: return CW'($urandom_range(1, 5));
		endcase
	endfunction

	initial begin : stimulus
		stim_row_t row;
		int        sent;
		sent = 0;
		restart_frame();

		// early flush under reset geometry, then a dropped partial frame
		row_px(8'h00, 1'b1);
		row_px(8'hA5, 1'b0);
		row_px(8'h5A, 1'b0);
		// zero width and height act as 1x1
		row_cfg(REG_WIDTH, '0);
		row_cfg(REG_HEIGHT, '0);
		row_cfg(REG_MODE, CW'(MODE_SMOOTH));
		row_px(8'hFF, 1'b0);
		row_px(8'h00, 1'b1);
		row_chk(8'h00, 1'b1, 8'hFF, 1'b1);
		row_cfg(REG_MODE, CW'(MODE_SHARP));
		row_px(8'h00, 1'b0);
		row_px(8'h00, 1'b1);
		row_chk(8'h00, 1'b1, 8'h00, 1'b1);
		row_cfg(REG_MODE, CW'(MODE_BAND));
		row_px(8'hFF, 1'b0);
		row_px(8'h00, 1'b1);
		row_chk(8'h00, 1'b1, 8'h00, 1'b1);
		// unused mode smooths; pixels while draining are dropped
		row_cfg(REG_MODE, CW'(MODE_UNUSED));
		row_px(8'h80, 1'b0);
		row_px(8'h11, 1'b0);
		row_chk(8'h22, 1'b0, 8'h80, 1'b1);
		row_cfg(REG_WIDTH, 13'd3);
		row_cfg(REG_HEIGHT, 13'd2);
		row_cfg(REG_MODE, CW'(MODE_SHARP));
		for (int i = 0; i < 6; i++)
			row_px((i % 2) ? 8'hFF : 8'h00, 1'b0);
		for (int i = 0; i < 4; i++)
			row_px(8'h00, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 78;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg)
				apb_write(row.reg_idx, row.value);
			else
				send_item(row.pix, row.flush, row.tag);
		end

		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 7;
				recv_idle_pct = 78;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 78;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if ($urandom_range(2) == 0)
				run_frame($urandom_range(1, cur_w * cur_h + cur_w), sent);
			apb_write(REG_WIDTH, rand_width());
			apb_write(REG_HEIGHT, rand_height());
			apb_write(REG_MODE, CW'($urandom_range(3)));
			repeat ($urandom_range(1, 4))
				run_frame(cur_w * cur_h + cur_w + 1, sent);
		end

		// widest row the block allows, cut short; then a tall single column
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apb_write(REG_WIDTH, {CW{1'b1}});
		apb_write(REG_HEIGHT, 13'd1);
		apb_write(REG_MODE, CW'($urandom_range(3)));
		run_frame(200, sent);
		apb_write(REG_WIDTH, 13'd1);
		apb_write(REG_HEIGHT, 13'd250);
		run_frame(cur_w * cur_h + cur_w + 1, sent);

		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS conv3x3_box_filter_unit");
		else
			$display("FAIL conv3x3_box_filter_unit");
		$finish;
	end

endmodule
